// File: hdl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// File: hdl/ddmp_pkg.sv
// Shared types and op codes for the differential-drive plant step unit.
// No dependencies.
package ddmp_pkg;
	// register indexes
	localparam logic [2:0] REG_MODE = 3'd0;
	localparam logic [2:0] REG_VLIM = 3'd1;
	localparam logic [2:0] REG_KEMF = 3'd2;
	localparam logic [2:0] REG_RES  = 3'd3;
	localparam logic [2:0] REG_INVL = 3'd4;
	localparam logic [2:0] REG_KT   = 3'd5;
	localparam logic [2:0] REG_DIAG = 3'd6;
	localparam logic [2:0] REG_CROSS = 3'd7;
	// datapath micro-ops
	localparam int OPW = 6;
	typedef logic [OPW-1:0] op_t;
	// last micro-op of a step
	localparam op_t OP_LAST = 6'd31;
	typedef struct packed {
		logic start;   // latch input word, init
		logic step;    // execute op
		op_t  op;
		logic done;    // commit state, load output
	} dp_cmd_t;
endpackage

// File: hdl/ddmp_datapath.sv
// Datapath of the plant step unit: a shared multiplier, two radius multipliers for the velocity sums, scratch regs.
// Depends on ddmp_pkg.
module ddmp_datapath #(
	parameter int FRAC_BITS = 16,
	parameter int WHEEL_RADIUS = 3277,
	parameter int INV_TRACK = 595782,
	parameter int COUPLING = 0,
	parameter int STATIC_FRICTION = 3277,
	parameter int VISCOUS_FRICTION = 13
) (
	input  logic clk,
	input  ddmp_pkg::dp_cmd_t cmd,
	input  logic signed [31:0] cmd_r, cmd_l,
	input  logic [30:0] dt_in,
	input  logic mode,
	input  logic [30:0] vlim, kemf, res, invl, kt,
	input  logic signed [31:0] diag, crs,
	input  logic arst_n,
	output logic signed [31:0] o_wr, o_wl, o_ir, o_il, o_vf, o_tr
);
	import ddmp_pkg::*;
	typedef logic signed [31:0] s32_t;
	localparam logic signed [63:0] SMAX = 64'sd2147483647;
	localparam logic signed [63:0] SMIN = -64'sd2147483648;

	function automatic s32_t sat(input logic signed [65:0] v);
		if (v > 66'(SMAX)) return s32_t'(SMAX);
		if (v < 66'(SMIN)) return s32_t'(SMIN);
		return s32_t'(v);
	endfunction

	s32_t cr_q, cl_q, wr_q, wl_q, ir_q, il_q, tr_q, a_q, b_q, c_q;
	s32_t nir_q, nil_q, t0_q, t1_q, nwr_q, nwl_q, frr_q, frl_q, cpl_q, p_q;
	logic [30:0] dt_q;

	// operand select
	logic signed [32:0] ma, mb;
	logic signed [65:0] prod, shp;
	logic [5:0] sh;
	always_comb begin
		ma = '0; mb = '0; sh = 6'(FRAC_BITS);
		case (cmd.op)
			6'd0:  begin ma = 33'(signed'(VISCOUS_FRICTION)); mb = 33'(wr_q); end
			6'd1:  begin ma = 33'(signed'(VISCOUS_FRICTION)); mb = 33'(wl_q); end
			6'd2:  begin ma = 33'(cr_q); mb = {2'b0, vlim}; end
			6'd3:  begin ma = {2'b0, kemf}; mb = 33'(wr_q); end
			6'd4:  begin ma = {2'b0, res}; mb = 33'(ir_q); end
			6'd6:  begin ma = 33'(a_q); mb = {2'b0, invl}; end
			6'd7:  begin ma = {2'b0, dt_q}; mb = 33'(a_q); end
			6'd8:  begin ma = 33'(cl_q); mb = {2'b0, vlim}; end
			6'd9:  begin ma = {2'b0, kemf}; mb = 33'(wl_q); end
			6'd10: begin ma = {2'b0, res}; mb = 33'(il_q); end
			6'd12: begin ma = 33'(a_q); mb = {2'b0, invl}; end
			6'd13: begin ma = {2'b0, dt_q}; mb = 33'(a_q); end
			6'd14: begin ma = {2'b0, kt}; mb = 33'(nir_q); end
			6'd15: begin ma = {2'b0, kt}; mb = 33'(nil_q); end
			6'd16: begin ma = 33'(signed'(COUPLING)); mb = 33'(tr_q); end
			6'd17: begin ma = 33'(cpl_q); mb = 33'(wl_q); end
			6'd18: begin ma = 33'(cpl_q); mb = 33'(wr_q); end
			6'd21: begin ma = 33'(diag); mb = 33'(t0_q); end
			6'd22: begin ma = 33'(crs); mb = 33'(t1_q); end
			6'd23: begin ma = 33'(crs); mb = 33'(t0_q); end
			6'd24: begin ma = 33'(diag); mb = 33'(t1_q); end
			6'd25: begin ma = {2'b0, dt_q}; mb = 33'(a_q); end
			6'd26: begin ma = {2'b0, dt_q}; mb = 33'(b_q); end
			6'd27: begin ma = 33'(signed'(WHEEL_RADIUS)); mb = 33'(nwr_q); end
			6'd28: begin ma = 33'(signed'(WHEEL_RADIUS)); mb = 33'(nwl_q); end
			6'd31: begin ma = 33'(signed'(INV_TRACK)); mb = 33'(c_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end
	assign prod = 66'(ma) * 66'(mb);
	assign shp = prod >>> sh;
	// exact 64-bit products for the velocity sums
	logic signed [65:0] rwr, rwl;
	assign rwr = 66'(signed'(WHEEL_RADIUS)) * 66'(nwr_q);
	assign rwl = 66'(signed'(WHEEL_RADIUS)) * 66'(nwl_q);
	s32_t m;
	assign m = sat(shp);

	function automatic s32_t sgnf(input s32_t w);
		if (w > 0) return s32_t'(STATIC_FRICTION);
		if (w < 0) return -s32_t'(STATIC_FRICTION);
		return '0;
	endfunction
	function automatic s32_t clampv(input s32_t u, input logic [30:0] l);
		if (66'(u) > 66'(signed'({1'b0, l}))) return s32_t'({1'b0, l});
		if (66'(u) < -66'(signed'({1'b0, l}))) return -s32_t'({1'b0, l});
		return u;
	endfunction

	// three-term sums saturate once: first product parks in p_q or c_q
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cr_q <= cmd_r; cl_q <= cmd_l; dt_q <= dt_in;
		end
		if (cmd.step) begin
			case (cmd.op)
				6'd0: frr_q <= sat(66'(sgnf(wr_q)) + 66'(m));
				6'd1: frl_q <= sat(66'(sgnf(wl_q)) + 66'(m));
				6'd2: a_q <= clampv(m, vlim);
				6'd3: p_q <= m;
				6'd4: a_q <= sat(66'(a_q) - 66'(p_q) - 66'(m));
				6'd6: a_q <= m;
				6'd7: nir_q <= sat(66'(ir_q) + 66'(m));
				6'd8: a_q <= clampv(m, vlim);
				6'd9: p_q <= m;
				6'd10: a_q <= sat(66'(a_q) - 66'(p_q) - 66'(m));
				6'd12: a_q <= m;
				6'd13: nil_q <= sat(66'(il_q) + 66'(m));
				6'd14: t0_q <= mode ? cr_q : m;
				6'd15: t1_q <= mode ? cl_q : m;
				6'd16: cpl_q <= m;
				6'd17: c_q <= m;
				6'd18: p_q <= m;
				6'd19: t0_q <= sat(66'(t0_q) - 66'(c_q) - 66'(frr_q));
				6'd20: t1_q <= sat(66'(t1_q) + 66'(p_q) - 66'(frl_q));
				6'd21: p_q <= m;
				6'd22: a_q <= sat(66'(p_q) + 66'(m));
				6'd23: p_q <= m;
				6'd24: b_q <= sat(66'(p_q) + 66'(m));
				6'd25: nwr_q <= sat(66'(wr_q) + 66'(m));
				6'd26: nwl_q <= sat(66'(wl_q) + 66'(m));
				6'd29: p_q <= sat((rwr + rwl) >>> (FRAC_BITS + 1));
				6'd30: c_q <= sat((rwr - rwl) >>> FRAC_BITS);
				6'd31: b_q <= m;
				default: ;
			endcase
		end
	end

	// committed state and output word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; wl_q <= '0; ir_q <= '0; il_q <= '0; tr_q <= '0;
		end else if (cmd.done) begin
			wr_q <= nwr_q; wl_q <= nwl_q; ir_q <= nir_q; il_q <= nil_q; tr_q <= b_q;
		end
	end
	always_ff @(posedge clk) begin
		if (cmd.done) begin
			o_wr <= nwr_q; o_wl <= nwl_q; o_ir <= nir_q; o_il <= nil_q;
			o_vf <= p_q; o_tr <= b_q;
		end
	end
endmodule

// File: hdl/ddmp_ctrl.sv
// Sequencer for the plant step: walks the micro-op list, runs the handshakes.
// Depends on ddmp_pkg.
module ddmp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output ddmp_pkg::dp_cmd_t cmd
);
	import ddmp_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RUN  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	logic [1:0] state_q;
	op_t pc_q;
	logic hold;
	// output register busy and not being taken
	assign hold = out_valid && out_stall;
	assign in_stall = (state_q != S_IDLE);
	always_comb begin
		cmd.start = (state_q == S_IDLE) && in_valid;
		cmd.step = (state_q == S_RUN);
		cmd.op = pc_q;
		cmd.done = (state_q == S_FIN) && !hold;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; pc_q <= '0; out_valid <= 1'b0;
		end else begin
			if (state_q == S_FIN && !hold) out_valid <= 1'b1;
			else if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) begin state_q <= S_RUN; pc_q <= '0; end
				S_RUN: begin
					if (pc_q == OP_LAST) state_q <= S_FIN;
					else pc_q <= pc_q + op_t'(1);
				end
				S_FIN: if (!hold) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/diff_drive_motor_plant_step_unit.sv
// Top level of the differential-drive plant step unit: APB registers, sequencer, datapath.
// Depends on ddmp_pkg, ddmp_ctrl, ddmp_datapath.
//
//  channel | handshake          | word
//  in      | in_valid/in_stall  | right_command, left_command, time_step
//  out     | out_valid/out_stall| wheel speeds, currents, forward_velocity, turn_rate
//  cfg     | APB, pready high   | 8 registers at 4*i
//
// A word runs from accept through 32 micro-ops on the shared multiplier to a commit
// step, and the next word is accepted after commit; the result sits in the output
// register from the cycle after commit.
// The next word is accepted while a result waits; commit holds if it is not taken.
// Reset clears the plant state and restores register defaults.
module diff_drive_motor_plant_step_unit #(
	parameter int FRAC_BITS = 16,
	parameter int WHEEL_RADIUS = 3277,
	parameter int INV_TRACK = 595782,
	parameter int COUPLING = 0,
	parameter int STATIC_FRICTION = 3277,
	parameter int VISCOUS_FRICTION = 13
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic signed [31:0] right_command,
	input  logic signed [31:0] left_command,
	input  logic [30:0] time_step,
	output logic out_valid,
	input  logic out_stall,
	output logic signed [31:0] right_wheel_speed,
	output logic signed [31:0] left_wheel_speed,
	output logic signed [31:0] right_current,
	output logic signed [31:0] left_current,
	output logic signed [31:0] forward_velocity,
	output logic signed [31:0] turn_rate,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [4:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import ddmp_pkg::*;
	logic mode_q;
	logic [30:0] vlim_q, kemf_q, res_q, invl_q, kt_q;
	logic signed [31:0] diag_q, cross_q;
	dp_cmd_t cmd;
	logic [2:0] ridx;
	assign pready = 1'b1;
	assign ridx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0; vlim_q <= 31'd327680; kemf_q <= 31'd20054;
			res_q <= 31'd163840; invl_q <= 31'd6553600; kt_q <= 31'd20054;
			diag_q <= 32'sd47354347; cross_q <= -32'sd2922906;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
			unique case (ridx)
				REG_MODE: mode_q <= pwdata[0];
				REG_VLIM: vlim_q <= pwdata[30:0];
				REG_KEMF: kemf_q <= pwdata[30:0];
				REG_RES:  res_q <= pwdata[30:0];
				REG_INVL: invl_q <= pwdata[30:0];
				REG_KT:   kt_q <= pwdata[30:0];
				REG_DIAG: diag_q <= pwdata;
				REG_CROSS: cross_q <= pwdata;
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (ridx)
			REG_MODE: prdata = {31'b0, mode_q};
			REG_VLIM: prdata = {1'b0, vlim_q};
			REG_KEMF: prdata = {1'b0, kemf_q};
			REG_RES:  prdata = {1'b0, res_q};
			REG_INVL: prdata = {1'b0, invl_q};
			REG_KT:   prdata = {1'b0, kt_q};
			REG_DIAG: prdata = diag_q;
			REG_CROSS: prdata = cross_q;
			default: prdata = '0;
		endcase
	end

	ddmp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
	);
	ddmp_datapath #(
		.FRAC_BITS(FRAC_BITS), .WHEEL_RADIUS(WHEEL_RADIUS), .INV_TRACK(INV_TRACK),
		.COUPLING(COUPLING), .STATIC_FRICTION(STATIC_FRICTION),
		.VISCOUS_FRICTION(VISCOUS_FRICTION)
	) u_dp (
		.clk(clk), .cmd(cmd), .cmd_r(right_command), .cmd_l(left_command),
		.dt_in(time_step), .mode(mode_q), .vlim(vlim_q), .kemf(kemf_q), .res(res_q),
		.invl(invl_q), .kt(kt_q), .diag(diag_q), .crs(cross_q), .arst_n(arst_n),
		.o_wr(right_wheel_speed), .o_wl(left_wheel_speed), .o_ir(right_current),
		.o_il(left_current), .o_vf(forward_velocity), .o_tr(turn_rate)
	);
endmodule

// File: hdl/ddmp_checker.sv
// Port-level checks for the plant step unit, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module ddmp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic pready
);
	// a word is taken only when the unit is free: next cycle it must be busy
	`AST_NXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall)
	// with no result pending at an accept, none appears in the cycle right after it
	`AST_NXT(a_noearly, clk, arst_n, in_valid && !in_stall && !out_valid, !out_valid)
	// stalled result stays valid
	`AST_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`AST_IMP(a_rdy, clk, arst_n, 1'b1, pready)
endmodule

bind diff_drive_motor_plant_step_unit ddmp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .pready(pready)
);
